// ===== rtl/core/mmsh_pkg.sv =====
`timescale 1ns / 1ps
// Package for the multi-mode string hash: mode codes, seeds, polynomials,
// the control bundle passed to the datapath, and the CRC and finish helpers.
// No dependencies.
package mmsh_pkg;

    localparam logic [2:0] MODE_ROL    = 3'd0;
    localparam logic [2:0] MODE_ROR    = 3'd1;
    localparam logic [2:0] MODE_CRC32  = 3'd2;
    localparam logic [2:0] MODE_CRC32C = 3'd3;
    localparam logic [2:0] MODE_DJB2   = 3'd4;
    localparam logic [2:0] MODE_SDBM   = 3'd5;

    localparam logic [31:0] POLY_CRC32  = 32'hEDB8_8320;
    localparam logic [31:0] POLY_CRC32C = 32'h82F6_3B78;
    localparam logic [31:0] ALL_ONES32  = 32'hFFFF_FFFF;
    localparam logic [63:0] DJB2_SEED   = 64'd5381;

    typedef struct packed {
        logic at_start;
        logic zero_seen;
        logic empty;
    } t_item_ctrl;

    function automatic logic [63:0] seed_for(input logic [2:0] mode);
        logic [63:0] seed;
        case (mode)
            MODE_CRC32, MODE_CRC32C: seed = {32'd0, ALL_ONES32};
            MODE_DJB2:               seed = DJB2_SEED;
            default:                 seed = 64'd0;
        endcase
        return seed;
    endfunction

    // One byte of a reflected CRC, eight bit steps unrolled.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data,
                                             input logic [31:0] poly);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            crc = crc[0] ? ((crc >> 1) ^ poly) : (crc >> 1);
        end
        return crc;
    endfunction

    function automatic logic [63:0] finish(input logic [2:0]  mode,
                                           input logic [63:0] acc);
        logic [63:0] res;
        case (mode)
            MODE_ROL, MODE_ROR:      res = acc;
            MODE_CRC32, MODE_CRC32C: res = {32'd0, acc[31:0] ^ ALL_ONES32};
            MODE_DJB2, MODE_SDBM:    res = (acc == 64'd0) ? 64'd1 : acc;
            default:                 res = 64'd0;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/core/mmsh_datapath.sv =====
`timescale 1ns / 1ps
// Combinational hash update: absorbs one byte into the accumulator under the
// selected mode and forms the finished hash. Depends on mmsh_pkg.
module mmsh_datapath (
    input  logic [2:0]          i_mode,
    input  logic [63:0]         i_acc,
    input  mmsh_pkg::t_item_ctrl i_ctrl,
    input  logic [7:0]          i_byte,
    output logic [63:0]         o_acc_next,
    output logic                o_zero_seen_next,
    output logic [63:0]         o_hash
);
    import mmsh_pkg::*;

    logic [63:0] seed;
    logic [63:0] acc_in;
    logic        zero_in;
    logic [63:0] sx_byte;
    logic [63:0] ext_byte;
    logic [63:0] absorbed;
    logic        zero_out;
    logic        stop;

    always_comb begin
        seed     = seed_for(i_mode);
        acc_in   = i_ctrl.at_start ? seed : i_acc;
        zero_in  = i_ctrl.at_start ? 1'b0 : i_ctrl.zero_seen;
        sx_byte  = {{56{i_byte[7]}}, i_byte};
        ext_byte = {56'd0, i_byte};
        stop     = zero_in || (i_byte == 8'd0);
        absorbed = acc_in;
        zero_out = zero_in;
        case (i_mode)
            MODE_ROL:    absorbed = {acc_in[62:0], acc_in[63]} ^ sx_byte;
            MODE_ROR:    absorbed = {acc_in[0], acc_in[63:1]} ^ sx_byte;
            MODE_CRC32:  absorbed = {32'd0, crc_byte(acc_in[31:0], i_byte, POLY_CRC32)};
            MODE_CRC32C: absorbed = {32'd0, crc_byte(acc_in[31:0], i_byte, POLY_CRC32C)};
            MODE_DJB2: begin
                if (stop) begin
                    zero_out = 1'b1;
                end else begin
                    absorbed = (acc_in << 5) + acc_in + ext_byte;
                end
            end
            MODE_SDBM: begin
                if (stop) begin
                    zero_out = 1'b1;
                end else begin
                    absorbed = ext_byte + (acc_in << 6) + (acc_in << 16) - acc_in;
                end
            end
            default:     absorbed = acc_in;
        endcase

        // An empty string leaves the running state alone and reports the seed.
        if (i_ctrl.empty) begin
            o_acc_next       = i_acc;
            o_zero_seen_next = 1'b0;
            o_hash           = finish(i_mode, seed);
        end else begin
            o_acc_next       = absorbed;
            o_zero_seen_next = zero_out;
            o_hash           = finish(i_mode, absorbed);
        end
    end

endmodule

// ===== rtl/core/multi_mode_string_hash.sv =====
`timescale 1ns / 1ps
// Multi-mode string hash, one byte per item. Depends on mmsh_pkg, mmsh_datapath.
// Results pass the input register, then the result register, before they are valid.
// Throughput: one item per cycle while the output accepts results; the byte update
// is one combinational pass between the input and accumulator/result registers.
// Reset (synchronous, active low): mode 0, accumulator 0, pipeline empty,
// next byte starts a new string.
module multi_mode_string_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_empty_string,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_hash_value
);
    import mmsh_pkg::*;

    logic [2:0]  r_mode;
    logic [63:0] r_acc;
    logic        r_at_start;
    logic        r_zero_seen;
    logic        r_s1_valid;
    logic [7:0]  r_s1_byte;
    logic        r_s1_last;
    logic        r_s1_empty;
    logic        r_out_valid;
    logic [63:0] r_hash;

    t_item_ctrl  ctrl;
    logic [63:0] n_acc;
    logic        n_zero_seen;
    logic [63:0] n_hash;
    logic        s1_has_result;
    logic        out_free;
    logic        s1_fire;
    logic        in_fire;

    assign ctrl.at_start  = r_at_start;
    assign ctrl.zero_seen = r_zero_seen;
    assign ctrl.empty     = r_s1_empty;

    mmsh_datapath u_datapath (
        .i_mode           (r_mode),
        .i_acc            (r_acc),
        .i_ctrl           (ctrl),
        .i_byte           (r_s1_byte),
        .o_acc_next       (n_acc),
        .o_zero_seen_next (n_zero_seen),
        .o_hash           (n_hash)
    );

    assign s1_has_result = r_s1_last || r_s1_empty;
    assign out_free      = !r_out_valid || i_out_ready;
    // Hold a result-bearing item only while the full output register is not read.
    assign s1_fire       = r_s1_valid && (!s1_has_result || out_free);
    assign o_in_ready    = !r_s1_valid || s1_fire;
    assign in_fire       = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_ROL;
            r_acc       <= 64'd0;
            r_at_start  <= 1'b1;
            r_zero_seen <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_acc       <= n_acc;
                r_zero_seen <= n_zero_seen;
                r_at_start  <= s1_has_result;
            end
            if (s1_fire && s1_has_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_byte  <= i_data_byte;
            r_s1_last  <= i_last_byte;
            r_s1_empty <= i_empty_string;
        end
        if (s1_fire && s1_has_result) begin
            r_hash <= n_hash;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_hash;

endmodule

// ===== verif/multi_mode_string_hash_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for multi_mode_string_hash: directed table, then random strings.
// Models the six modes to predict each unpinned hash. Depends on mmsh_pkg and the RTL.
module multi_mode_string_hash_tb;
    import mmsh_pkg::*;

    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;
    localparam int ITEM_TARGET    = 1150;
    localparam int PIPE_SETTLE    = 4;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 24;
    localparam int NUM_ROWS       = 33;

    typedef enum logic { ROW_BYTE, ROW_MODE } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [7:0]  data;    // byte, or the mode for a ROW_MODE row
        logic        last;
        logic        empty;
        logic        pinned;  // hash below is typed in rather than predicted
        logic [63:0] hash;
    } t_stim_row;

    localparam t_stim_row DIRECTED [0:NUM_ROWS-1] = '{
        '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, 1'b1, 64'd0},  // empty after reset, payload ignored
        '{ROW_BYTE, 8'hFF, 1'b1, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
        '{ROW_BYTE, 8'h80, 1'b0, 1'b0, 1'b0, 64'd0},
        '{ROW_BYTE, 8'h7F, 1'b1, 1'b0, 1'b0, 64'd0},
        '{ROW_MODE, {5'd0, MODE_ROR}, 1'b0, 1'b0, 1'b0, 64'd0},
        '{ROW_BYTE, 8'h01, 1'b1, 1'b0, 1'b1, 64'd1},
        '{ROW_BYTE, 8'h80, 1'b0, 1'b0, 1'b0, 64'd0},
        '{ROW_BYTE, 8'h80, 1'b1, 1'b0, 1'b0, 64'd0},
        '{ROW_MODE, {5'd0, MODE_CRC32}, 1'b0, 1'b0, 1'b0, 64'd0},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b1, 1'b1, 64'd0},
        '{ROW_BYTE, 8'h00, 1'b1, 1'b0, 1'b0, 64'd0},
        '{ROW_MODE, {5'd0, MODE_CRC32C}, 1'b0, 1'b0, 1'b0, 64'd0},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b1, 1'b1, 64'd0},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, 64'd0},
        '{ROW_BYTE, 8'hFF, 1'b1, 1'b0, 1'b0, 64'd0},
        '{ROW_MODE, {5'd0, MODE_DJB2}, 1'b0, 1'b0, 1'b0, 64'd0},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b1, 1'b1, 64'd5381},
        '{ROW_BYTE, 8'h00, 1'b1, 1'b0, 1'b1, 64'd5381},
        '{ROW_BYTE, 8'h61, 1'b0, 1'b0, 1'b0, 64'd0},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, 64'd0},  // bytes after a zero are dropped
        '{ROW_BYTE, 8'hFF, 1'b1, 1'b0, 1'b0, 64'd0},
        '{ROW_BYTE, 8'h41, 1'b0, 1'b0, 1'b0, 64'd0},  // string left open across a mode change
        '{ROW_MODE, {5'd0, MODE_SDBM}, 1'b0, 1'b0, 1'b0, 64'd0},
        '{ROW_BYTE, 8'h42, 1'b1, 1'b0, 1'b0, 64'd0},
        '{ROW_BYTE, 8'h00, 1'b0, 1'b1, 1'b1, 64'd1},
        '{ROW_BYTE, 8'h00, 1'b1, 1'b0, 1'b1, 64'd1},
        '{ROW_BYTE, 8'hFF, 1'b1, 1'b0, 1'b1, 64'd255},
        '{ROW_MODE, {5'd0, MODE_SPARE6}, 1'b0, 1'b0, 1'b0, 64'd0},
        '{ROW_BYTE, 8'h55, 1'b1, 1'b0, 1'b1, 64'd0},
        '{ROW_MODE, {5'd0, MODE_SPARE7}, 1'b0, 1'b0, 1'b0, 64'd0},
        '{ROW_BYTE, 8'hAA, 1'b0, 1'b0, 1'b0, 64'd0},
        '{ROW_BYTE, 8'hAA, 1'b1, 1'b1, 1'b1, 64'd0},  // empty discards the open string
        '{ROW_MODE, {5'd0, MODE_ROL}, 1'b0, 1'b0, 1'b0, 64'd0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        i_empty_string;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [63:0] o_hash_value;

    // predictor state
    logic [2:0]  mdl_mode;
    logic [63:0] mdl_acc;
    logic        mdl_fresh;
    logic        mdl_zero;

    logic [63:0] hash_expected_q[$];

    int  errors;
    int  items_sent;
    int  hashes_checked;
    int  mode_writes;
    int  in_stall_cycles;
    int  idle_cycles;
    int  pending_gap;
    bit  tx_burst;
    bit  rx_burst;
    bit  rx_long_hold;

    multi_mode_string_hash u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_empty_string (i_empty_string),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_hash_value   (o_hash_value)
    );

    always #6 i_clk = ~i_clk;

    function automatic int draw_gap(input bit burst);
        if (burst || $urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 16);
    endfunction

    function automatic logic [63:0] hash_seed(input logic [2:0] m);
        if (m == MODE_CRC32 || m == MODE_CRC32C) return {32'd0, ALL_ONES32};
        if (m == MODE_DJB2) return DJB2_SEED;
        return 64'd0;
    endfunction

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b,
                                             input logic [31:0] poly);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        repeat (8) r = (r >> 1) ^ (r[0] ? poly : 32'd0);
        return r;
    endfunction

    function automatic logic [63:0] hash_close(input logic [2:0] m, input logic [63:0] a);
        logic [63:0] h;
        case (m)
            MODE_ROL, MODE_ROR:      h = a;
            MODE_CRC32, MODE_CRC32C: h = {32'd0, ~a[31:0]};
            MODE_DJB2, MODE_SDBM:    h = (a != 64'd0) ? a : 64'd1;
            default:                 h = 64'd0;
        endcase
        return h;
    endfunction

    // Advance the predictor by one item; return 1 when the item finishes a hash.
    function automatic bit hash_predict(input logic [7:0] b, input logic last,
                                        input logic empty, output logic [63:0] hash);
        logic [63:0] sx;
        logic [63:0] a;
        hash = 64'd0;
        if (empty) begin
            mdl_zero  = 1'b0;
            mdl_fresh = 1'b1;
            hash      = hash_close(mdl_mode, hash_seed(mdl_mode));
            return 1'b1;
        end
        if (mdl_fresh) begin
            mdl_acc   = hash_seed(mdl_mode);
            mdl_zero  = 1'b0;
            mdl_fresh = 1'b0;
        end
        sx = {{56{b[7]}}, b};
        a  = mdl_acc;
        case (mdl_mode)
            MODE_ROL:    a = {a[62:0], a[63]} ^ sx;
            MODE_ROR:    a = {a[0], a[63:1]} ^ sx;
            MODE_CRC32:  a = {32'd0, crc_step(a[31:0], b, POLY_CRC32)};
            MODE_CRC32C: a = {32'd0, crc_step(a[31:0], b, POLY_CRC32C)};
            MODE_DJB2: begin
                if (mdl_zero || b == 8'd0) mdl_zero = 1'b1;
                else a = (a << 5) + a + {56'd0, b};
            end
            MODE_SDBM: begin
                if (mdl_zero || b == 8'd0) mdl_zero = 1'b1;
                else a = {56'd0, b} + (a << 6) + (a << 16) - a;
            end
            default: ;
        endcase
        mdl_acc = a;
        if (!last) return 1'b0;
        hash      = hash_close(mdl_mode, a);
        mdl_fresh = 1'b1;
        return 1'b1;
    endfunction

    task automatic send_item(input logic [7:0] b, input logic last, input logic empty,
                             input logic pinned, input logic [63:0] pin_hash);
        logic [63:0] h;
        if (pending_gap > 0) repeat (pending_gap) @(posedge i_clk);
        i_in_valid     <= 1'b1;
        i_data_byte    <= b;
        i_last_byte    <= last;
        i_empty_string <= empty;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        if (hash_predict(b, last, empty, h)) hash_expected_q.push_back(pinned ? pin_hash : h);
        // keep valid up when the next item follows at once
        pending_gap = draw_gap(tx_burst);
        if (pending_gap != 0) i_in_valid <= 1'b0;
    endtask

    task automatic hold_input();
        if (pending_gap == 0) begin
            i_in_valid  <= 1'b0;
            pending_gap = 1;
        end
    endtask

    task automatic set_mode(input logic [2:0] m);
        hold_input();
        while (hash_expected_q.size() != 0) @(posedge i_clk);
        // let an open string's last byte clear the pipeline
        repeat (PIPE_SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mdl_mode = m;
        mode_writes++;
    endtask

    task automatic send_string();
        int          len;
        logic [7:0]  b;
        if ($urandom_range(0, 11) == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, 1'b0, 64'd0);
            return;
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
            b = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 19))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: ;
            endcase
            // break the string now and then with an empty item
            if (k < len - 1 && $urandom_range(0, 29) == 0)
                send_item(b, 1'($urandom_range(0, 1)), 1'b1, 1'b0, 64'd0);
            send_item(b, k == len - 1, 1'b0, 1'b0, 64'd0);
        end
    endtask

    // receiver: random hold-offs, check each hash against the oldest expectation
    initial begin
        int          gap;
        logic [63:0] want;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = draw_gap(rx_burst);
            if (rx_long_hold) begin
                gap          = LONG_HOLD;
                rx_long_hold = 1'b0;
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            if (hash_expected_q.size() == 0) begin
                $error("hash_value with no item waiting: actual %h", o_hash_value);
                errors++;
            end else begin
                want = hash_expected_q.pop_front();
                hashes_checked++;
                if (o_hash_value !== want) begin
                    $error("hash_value mismatch: expected %h actual %h", want, o_hash_value);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_ready) in_stall_cycles++;
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [2:0] m;
        int         nstr;
        i_clk          = 1'b0;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_data     <= MODE_ROL;
        i_in_valid     <= 1'b0;
        i_data_byte    <= 8'd0;
        i_last_byte    <= 1'b0;
        i_empty_string <= 1'b0;
        i_out_ready    <= 1'b0;
        mdl_mode       = MODE_ROL;
        mdl_acc        = 64'd0;
        mdl_fresh      = 1'b1;
        mdl_zero       = 1'b0;
        errors         = 0;
        items_sent     = 0;
        hashes_checked = 0;
        mode_writes    = 0;
        in_stall_cycles = 0;
        idle_cycles    = 0;
        pending_gap    = 1;
        tx_burst       = 1'b0;
        rx_burst       = 1'b0;
        rx_long_hold   = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_MODE)
                set_mode(DIRECTED[r].data[2:0]);
            else
                send_item(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].empty,
                          DIRECTED[r].pinned, DIRECTED[r].hash);
        end

        // stall the output for a long stretch so the block backs up its input
        set_mode(MODE_CRC32);
        tx_burst     = 1'b1;
        rx_long_hold = 1'b1;
        repeat (60) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, 64'd0);
        tx_burst = 1'b0;

        while (items_sent < ITEM_TARGET) begin
            m = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 5));
            set_mode(m);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            nstr     = $urandom_range(8, 30);
            repeat (nstr) send_string();
            // leave a string open so the next mode takes over mid-string
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 4))
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 64'd0);
        end

        hold_input();
        rx_burst = 1'b1;
        while (hash_expected_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d items over %0d mode writes, checked %0d hashes",
                 items_sent, mode_writes, hashes_checked);
        $display("Input held off by the block for %0d cycles, %0d mismatches",
                 in_stall_cycles, errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== multi_mode_string_hash.f =====
rtl/core/mmsh_pkg.sv
rtl/core/mmsh_datapath.sv
rtl/core/multi_mode_string_hash.sv
verif/multi_mode_string_hash_tb.sv
